>>> rtl/forward_collision_warning_top_defines.svh
// Assertion macros for the forward collision warning block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FORWARD_COLLISION_WARNING_TOP_DEFINES_SVH
`define FORWARD_COLLISION_WARNING_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FCW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcw: same-cycle check failed");
// next-cycle implication
`define FCW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcw: next-cycle check failed");
`else
`define FCW_ASSERT_IMP(lbl, ante, cons)
`define FCW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/fcw_pkg.sv
`timescale 1ns / 1ps

package fcw_pkg;

    // field widths
    localparam int TRACK_W = 6;
    localparam int Q16_W   = 16;
    localparam int TTC_W   = 18;

    // counter store depth
    localparam int TRACK_COUNT = 64;

    // serial unit step counts
    localparam int MUL_STEPS = 16;
    localparam int DIV_STEPS = 18;

    // saturation values and limits
    localparam logic [TTC_W-1:0] TTC_MAX    = 18'd255744;
    localparam logic [TTC_W-1:0] DEC_OVER4  = 18'd1024;
    localparam logic [TTC_W-1:0] DEC_OVER2  = 18'd512;
    localparam logic [15:0]      CLOSE_MIN  = 16'd461;
    localparam logic [15:0]      COUNT_MAX  = 16'hFFFF;

    // raw and filtered alert codes
    localparam logic [1:0] ALERT_SAFE    = 2'd0;
    localparam logic [1:0] ALERT_CAUTION = 2'd1;
    localparam logic [1:0] ALERT_BRAKE   = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_TTC_BRAKE   = 3'd0;
    localparam logic [2:0] CFG_TTC_CAUTION = 3'd1;
    localparam logic [2:0] CFG_BRAKE_DIST  = 3'd2;
    localparam logic [2:0] CFG_CAUT_DIST   = 3'd3;
    localparam logic [2:0] CFG_HYST        = 3'd4;
    localparam logic [2:0] CFG_DEF_EGO     = 3'd5;

    // sequencer strobes into the arithmetic unit
    typedef struct packed {
        logic mul_load;
        logic mul_step;
        logic prep;
        logic div_init;
        logic div_step;
    } fcw_ctrl_t;

    // division results back to the sequencer
    typedef struct packed {
        logic [TTC_W-1:0] ttc_q;
        logic             ttc_ovf;
        logic [TTC_W-1:0] dec_q;
        logic             dec_ovf;
        logic             dec_rem_nz;
    } fcw_res_t;

endpackage

>>> rtl/fcw_arith.sv
`timescale 1ns / 1ps

// Bit-serial arithmetic: shift-add square of the closing speed, then two
// restoring dividers side by side, one quotient bit per cycle each.
module fcw_arith (
    input  logic              clk,
    input  fcw_pkg::fcw_ctrl_t ctrl,
    input  logic [15:0]       r,
    input  logic [15:0]       d,
    output fcw_pkg::fcw_res_t  res
);
    import fcw_pkg::*;

    // multiplier
    logic [31:0] mcand_reg;
    logic [15:0] mplier_reg;
    logic [31:0] prod_reg;

    // operands
    logic [38:0] num_reg;    // 100 * r * r
    logic [27:0] ddiv_reg;   // 2592 * d
    logic [29:0] tnum_reg;   // 9216 * d
    logic [19:0] tdiv_reg;   // 10 * r

    // divider state
    logic [19:0]      trem_reg;
    logic [TTC_W-1:0] tq_reg;
    logic             tovf_reg;
    logic [27:0]      drem_reg;
    logic [TTC_W-1:0] dq_reg;
    logic             dovf_reg;

    logic [38:0] num_next;
    logic [27:0] ddiv_next;
    logic [29:0] tnum_next;
    logic [19:0] tdiv_next;
    logic [20:0] t_sh;
    logic [20:0] t_sub;
    logic        t_ge;
    logic [28:0] d_sh;
    logic [28:0] d_sub;
    logic        d_ge;

    // constant multiplies as shift-add
    assign num_next  = (39'(prod_reg) << 6) + (39'(prod_reg) << 5) + (39'(prod_reg) << 2);
    assign ddiv_next = (28'(d) << 11) + (28'(d) << 9) + (28'(d) << 5);
    assign tnum_next = (30'(d) << 13) + (30'(d) << 10);
    assign tdiv_next = (20'(r) << 3) + (20'(r) << 1);

    // one restoring step for each divider
    assign t_sh  = {trem_reg, tq_reg[TTC_W-1]};
    assign t_ge  = t_sh >= {1'b0, tdiv_reg};
    assign t_sub = t_sh - {1'b0, tdiv_reg};
    assign d_sh  = {drem_reg, dq_reg[TTC_W-1]};
    assign d_ge  = d_sh >= {1'b0, ddiv_reg};
    assign d_sub = d_sh - {1'b0, ddiv_reg};

    // shift-add square
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_load)
        begin
            mcand_reg  <= {16'd0, r};
            mplier_reg <= r;
            prod_reg   <= 32'd0;
        end
        else if (ctrl.mul_step)
        begin
            if (mplier_reg[0])
            begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[30:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[15:1]};
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        if (ctrl.prep)
        begin
            num_reg  <= num_next;
            ddiv_reg <= ddiv_next;
            tnum_reg <= tnum_next;
            tdiv_reg <= tdiv_next;
        end
    end

    // dividers: overflow test on the upper part, then one bit a cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.div_init)
        begin
            tovf_reg <= {8'd0, tnum_reg[29:18]} >= tdiv_reg;
            trem_reg <= {8'd0, tnum_reg[29:18]};
            tq_reg   <= tnum_reg[17:0];
            dovf_reg <= {7'd0, num_reg[38:18]} >= ddiv_reg;
            drem_reg <= {7'd0, num_reg[38:18]};
            dq_reg   <= num_reg[17:0];
        end
        else if (ctrl.div_step)
        begin
            trem_reg <= t_ge ? t_sub[19:0] : t_sh[19:0];
            tq_reg   <= {tq_reg[TTC_W-2:0], t_ge};
            drem_reg <= d_ge ? d_sub[27:0] : d_sh[27:0];
            dq_reg   <= {dq_reg[TTC_W-2:0], d_ge};
        end
    end

    assign res.ttc_q      = tq_reg;
    assign res.ttc_ovf    = tovf_reg;
    assign res.dec_q      = dq_reg;
    assign res.dec_ovf    = dovf_reg;
    assign res.dec_rem_nz = drem_reg != 28'd0;

endmodule

>>> rtl/forward_collision_warning_top.sv
// Flow: an accepted item steps through S_MLOAD, S_MUL (bit-serial squarer),
// S_PREP, S_DINIT, S_DIV (the two restoring dividers), S_CLASS and S_UPD;
// S_UPD waits until the output register is free, and input is taken in S_IDLE only.
// The next input is taken while a finished result waits at the output.
// Reset: rst_n asynchronous, active low; registers return to defaults and
// every per-track alert counter reads as zero (valid bits cleared at once).
`timescale 1ns / 1ps
`include "forward_collision_warning_top_defines.svh"

module forward_collision_warning_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] track_number, [21:6] target_distance, [37:22] target_speed,
    // [53:38] own_speed, [55:54] zero
    input  logic [55:0] s_axis_tdata,
    // [0] ego_given
    input  logic        s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] track_echo, [7:6] alert_level, [25:8] time_to_collision,
    // [41:26] distance_echo, [57:42] speed_echo, [73:58] needed_deceleration,
    // [79:74] zero
    output logic [79:0] m_axis_tdata
);
    import fcw_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MLOAD = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_DINIT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_CLASS = 3'd6;
    localparam logic [2:0] S_UPD   = 3'd7;

    localparam logic [4:0] MUL_LAST = 5'(MUL_STEPS - 1);
    localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

    // configuration registers
    logic [15:0] ttc_brake_reg;
    logic [15:0] ttc_caution_reg;
    logic [15:0] brake_dist_reg;
    logic [15:0] caution_dist_reg;
    logic [7:0]  hyst_reg;
    logic [15:0] def_ego_reg;

    // control
    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [4:0]  step_reg;
    logic [4:0]  step_next;
    logic        out_vld_reg;
    logic [TRACK_COUNT-1:0] cnt_vld_reg;
    logic        cnt_hit_reg;

    // item payload
    logic [TRACK_W-1:0] track_reg;
    logic [15:0] d_reg;
    logic [15:0] tgt_reg;
    logic [15:0] r_reg;
    logic        closing_reg;
    logic        dpos_reg;
    logic [15:0] cnt_rd_reg;
    logic [TTC_W-1:0] ttc_fin_reg;
    logic [15:0] dec_fin_reg;
    logic [1:0]  raw_reg;

    // output register
    logic [TRACK_W-1:0] out_track_reg;
    logic [1:0]  out_alert_reg;
    logic [TTC_W-1:0] out_ttc_reg;
    logic [15:0] out_dist_reg;
    logic [15:0] out_spd_reg;
    logic [15:0] out_dec_reg;

    // counter store
    logic [15:0] cnt_mem [TRACK_COUNT];

    logic        in_fire;
    logic        cfg_fire;
    logic        upd_fire;
    logic [TRACK_W-1:0] in_track;
    logic [15:0] in_dist;
    logic [15:0] in_tgt;
    logic [15:0] in_ego;
    logic [15:0] ego_sel;
    logic        ego_ahead;
    logic [15:0] r_next;

    fcw_ctrl_t   ctrl;
    fcw_res_t    res;

    logic [TTC_W-1:0] ttc_fin_next;
    logic [15:0] dec_fin_next;
    logic        over4;
    logic        over2;
    logic        brake_hit;
    logic        caution_hit;
    logic [1:0]  raw_next;
    logic [15:0] cnt_base;
    logic [15:0] cnt_next;
    logic [1:0]  level_next;

    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign s_axis_tready = state_reg == S_IDLE;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign upd_fire      = (state_reg == S_UPD) && (!out_vld_reg || m_axis_tready);

    // input unpacking and closing speed
    assign in_track  = s_axis_tdata[5:0];
    assign in_dist   = s_axis_tdata[21:6];
    assign in_tgt    = s_axis_tdata[37:22];
    assign in_ego    = s_axis_tdata[53:38];
    assign ego_sel   = s_axis_tuser ? in_ego : def_ego_reg;
    assign ego_ahead = ego_sel > in_tgt;
    assign r_next    = ego_ahead ? (ego_sel - in_tgt) : 16'd0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttc_brake_reg    <= 16'd384;
            ttc_caution_reg  <= 16'd768;
            brake_dist_reg   <= 16'd2560;
            caution_dist_reg <= 16'd6400;
            hyst_reg         <= 8'd3;
            def_ego_reg      <= 16'd15360;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_TTC_BRAKE:   ttc_brake_reg    <= cfg_data;
                CFG_TTC_CAUTION: ttc_caution_reg  <= cfg_data;
                CFG_BRAKE_DIST:  brake_dist_reg   <= cfg_data;
                CFG_CAUT_DIST:   caution_dist_reg <= cfg_data;
                CFG_HYST:        hyst_reg         <= cfg_data[7:0];
                CFG_DEF_EGO:     def_ego_reg      <= cfg_data;
                default:         ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_MLOAD;
                end
            end
            S_MLOAD:
            begin
                state_next = S_MUL;
                step_next  = 5'd0;
            end
            S_MUL:
            begin
                if (step_reg == MUL_LAST)
                begin
                    state_next = S_PREP;
                end
                step_next = step_reg + 5'd1;
            end
            S_PREP:  state_next = S_DINIT;
            S_DINIT:
            begin
                state_next = S_DIV;
                step_next  = 5'd0;
            end
            S_DIV:
            begin
                if (step_reg == DIV_LAST)
                begin
                    state_next = S_CLASS;
                end
                step_next = step_reg + 5'd1;
            end
            S_CLASS: state_next = S_UPD;
            S_UPD:
            begin
                if (upd_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // strobes for the arithmetic unit
    always_comb
    begin
        ctrl.mul_load = state_reg == S_MLOAD;
        ctrl.mul_step = state_reg == S_MUL;
        ctrl.prep     = state_reg == S_PREP;
        ctrl.div_init = state_reg == S_DINIT;
        ctrl.div_step = state_reg == S_DIV;
    end

    fcw_arith u_arith (
        .clk  (clk),
        .ctrl (ctrl),
        .r    (r_reg),
        .d    (d_reg),
        .res  (res)
    );

    // item capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            track_reg   <= in_track;
            d_reg       <= in_dist;
            tgt_reg     <= in_tgt;
            r_reg       <= r_next;
            closing_reg <= r_next >= CLOSE_MIN;
            dpos_reg    <= (r_next != 16'd0) && (in_dist != 16'd0);
        end
    end

    // saturation and raw classification
    always_comb
    begin
        if (!closing_reg || res.ttc_ovf || (res.ttc_q > TTC_MAX))
        begin
            ttc_fin_next = TTC_MAX;
        end
        else
        begin
            ttc_fin_next = res.ttc_q;
        end

        if (!dpos_reg)
        begin
            dec_fin_next = 16'd0;
        end
        else if (res.dec_ovf || (res.dec_q[TTC_W-1:16] != 2'd0))
        begin
            dec_fin_next = 16'hFFFF;
        end
        else
        begin
            dec_fin_next = res.dec_q[15:0];
        end

        // exact tests against 1024 and 512 times the divisor
        over4 = dpos_reg && (res.dec_ovf || (res.dec_q > DEC_OVER4) ||
                ((res.dec_q == DEC_OVER4) && res.dec_rem_nz));
        over2 = dpos_reg && (res.dec_ovf || (res.dec_q > DEC_OVER2) ||
                ((res.dec_q == DEC_OVER2) && res.dec_rem_nz));

        brake_hit   = ((ttc_fin_next < {2'b00, ttc_brake_reg}) || over4) &&
                      ({1'b0, d_reg} < {brake_dist_reg, 1'b0});
        caution_hit = ((ttc_fin_next < {2'b00, ttc_caution_reg}) || over2) &&
                      ({1'b0, d_reg} < {caution_dist_reg, 1'b0});

        if (brake_hit)
        begin
            raw_next = ALERT_BRAKE;
        end
        else if (caution_hit)
        begin
            raw_next = ALERT_CAUTION;
        end
        else
        begin
            raw_next = ALERT_SAFE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLASS)
        begin
            ttc_fin_reg <= ttc_fin_next;
            dec_fin_reg <= dec_fin_next;
            raw_reg     <= raw_next;
        end
    end

    // counter filter and final level
    always_comb
    begin
        cnt_base = cnt_hit_reg ? cnt_rd_reg : 16'd0;
        case (raw_reg)
            ALERT_BRAKE:   cnt_next = (cnt_base >= (COUNT_MAX - 16'd1)) ? COUNT_MAX
                                                                         : cnt_base + 16'd2;
            ALERT_CAUTION: cnt_next = (cnt_base == COUNT_MAX) ? COUNT_MAX : cnt_base + 16'd1;
            default:       cnt_next = (cnt_base != 16'd0) ? cnt_base - 16'd1 : 16'd0;
        endcase

        if ({1'b0, cnt_next} >= {8'd0, hyst_reg, 1'b0})
        begin
            level_next = ALERT_BRAKE;
        end
        else if (cnt_next >= {8'd0, hyst_reg})
        begin
            level_next = ALERT_CAUTION;
        end
        else
        begin
            level_next = ALERT_SAFE;
        end
    end

    // counter store, registered read at acceptance, write at update
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cnt_rd_reg <= cnt_mem[in_track];
        end
        if (upd_fire)
        begin
            cnt_mem[track_reg] <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg <= '0;
            cnt_hit_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                cnt_hit_reg <= cnt_vld_reg[in_track];
            end
            if (upd_fire)
            begin
                cnt_vld_reg[track_reg] <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            out_track_reg <= track_reg;
            out_alert_reg <= level_next;
            out_ttc_reg   <= ttc_fin_reg;
            out_dist_reg  <= d_reg;
            out_spd_reg   <= tgt_reg;
            out_dec_reg   <= dec_fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (upd_fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'd0, out_dec_reg, out_spd_reg, out_dist_reg,
                            out_ttc_reg, out_alert_reg, out_track_reg};

    // checks
    `FCW_ASSERT_NXT(a_accept_starts, in_fire, state_reg == S_MLOAD)
    `FCW_ASSERT_IMP(a_out_from_upd, $rose(out_vld_reg), $past(state_reg) == S_UPD)
    `FCW_ASSERT_NXT(a_far_ttc_max, upd_fire && !closing_reg, out_ttc_reg == TTC_MAX)

endmodule

>>> tb/sv/fcw_checker.sv
`timescale 1ns / 1ps

// Watches the config, target and alert channels of the collision warning
// block, predicts each alert transaction and compares it field by field.
module fcw_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [5:0] track_number, [21:6] target_distance, [37:22] target_speed,
    // [53:38] own_speed, [55:54] zero
    input  logic [55:0] s_axis_tdata,
    // [0] ego_given
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] track_echo, [7:6] alert_level, [25:8] time_to_collision,
    // [41:26] distance_echo, [57:42] speed_echo, [73:58] needed_deceleration
    input  logic [79:0] m_axis_tdata,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          brake_seen,
    output int          caution_seen,
    output int          writes_seen
);
    import fcw_pkg::*;

    // fixed-point constants of the time-to-collision, deceleration and counter arithmetic
    localparam logic [63:0] NOT_CLOSING  = 64'd255744;
    localparam logic [63:0] DECEL_SAT    = 64'd65535;
    localparam logic [63:0] CLOSE_THRESH = 64'd4608;
    localparam logic [63:0] TTC_SCALE    = 64'd9216;
    localparam logic [63:0] DECEL_SCALE  = 64'd2592;
    localparam logic [63:0] HARD_DECEL   = 64'd1024;
    localparam logic [63:0] FIRM_DECEL   = 64'd512;
    localparam logic [31:0] COUNT_SAT    = 32'd65535;

    // layout of one alert transaction, lowest field last
    typedef struct packed {
        logic [15:0] decel;
        logic [15:0] speed;
        logic [15:0] distance;
        logic [17:0] ttc;
        logic [1:0]  level;
        logic [5:0]  track;
    } alert_result_t;

    // shadow registers
    logic [15:0] lim_brake;
    logic [15:0] lim_caution;
    logic [15:0] brake_range;
    logic [15:0] caution_range;
    logic [7:0]  hyst;
    logic [15:0] def_ego;

    logic [15:0]   track_alert_count [TRACK_COUNT];
    alert_result_t pending_alerts [$];
    alert_result_t got;
    alert_result_t want;
    int            mismatches;
    int            checked;
    int            brakes;
    int            cautions;
    int            writes;

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // works out the alert for one target and advances its track counter
    task automatic predict_alert(input logic [55:0] data, input logic ego_given);
        logic [5:0]    track;
        logic [63:0]   d;
        logic [63:0]   tgt;
        logic [63:0]   ego;
        logic [63:0]   r;
        logic [63:0]   ttc;
        logic [63:0]   decel;
        logic [63:0]   num;
        logic          closing;
        logic          over_hard;
        logic          over_firm;
        logic [1:0]    raw;
        logic [1:0]    level;
        logic [31:0]   cnt;
        alert_result_t res;
        track = data[5:0];
        d     = {48'd0, data[21:6]};
        tgt   = {48'd0, data[37:22]};
        ego   = ego_given ? {48'd0, data[53:38]} : {48'd0, def_ego};

        // only the closing part of the relative speed counts
        closing = ego > tgt;
        r = closing ? ego - tgt : 64'd0;

        ttc = NOT_CLOSING;
        if (closing && r * 10 > CLOSE_THRESH)
        begin
            ttc = (d * TTC_SCALE) / (r * 10);
            if (ttc > NOT_CLOSING)
                ttc = NOT_CLOSING;
        end

        num   = r * r * 100;
        decel = 64'd0;
        if (closing && d != 0)
        begin
            decel = num / (DECEL_SCALE * d);
            if (decel > DECEL_SAT)
                decel = DECEL_SAT;
        end
        // exact deceleration tests, before truncation
        over_hard = closing && d != 0 && num > HARD_DECEL * DECEL_SCALE * d;
        over_firm = closing && d != 0 && num > FIRM_DECEL * DECEL_SCALE * d;

        raw = ALERT_SAFE;
        if ((ttc < {48'd0, lim_brake} || over_hard) && d < 2 * {48'd0, brake_range})
            raw = ALERT_BRAKE;
        else if ((ttc < {48'd0, lim_caution} || over_firm)
                 && d < 2 * {48'd0, caution_range})
            raw = ALERT_CAUTION;

        // per-track hysteresis counter, saturating upwards
        cnt = (track < TRACK_COUNT) ? {16'd0, track_alert_count[track]} : 32'd0;
        if (raw == ALERT_BRAKE)
            cnt = (cnt + 2 > COUNT_SAT) ? COUNT_SAT : cnt + 2;
        else if (raw == ALERT_CAUTION)
            cnt = (cnt + 1 > COUNT_SAT) ? COUNT_SAT : cnt + 1;
        else if (cnt > 0)
            cnt = cnt - 1;
        if (track < TRACK_COUNT)
            track_alert_count[track] = cnt[15:0];

        if (cnt >= 2 * {24'd0, hyst})
            level = ALERT_BRAKE;
        else if (cnt >= {24'd0, hyst})
            level = ALERT_CAUTION;
        else
            level = ALERT_SAFE;

        res.track    = track;
        res.level    = level;
        res.ttc      = ttc[17:0];
        res.distance = d[15:0];
        res.speed    = tgt[15:0];
        res.decel    = decel[15:0];
        pending_alerts = {pending_alerts, res};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_brake     = 16'd384;
            lim_caution   = 16'd768;
            brake_range   = 16'd2560;
            caution_range = 16'd6400;
            hyst          = 8'd3;
            def_ego       = 16'd15360;
            for (int i = 0; i < TRACK_COUNT; i++)
                track_alert_count[i] = 16'd0;
            pending_alerts.delete();
            mismatches = 0;
            checked    = 0;
            brakes     = 0;
            cautions   = 0;
            writes     = 0;
        end
        else
        begin
            // alert transaction against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[73:0];
                if (pending_alerts.size() == 0)
                begin
                    $error("alert for track %0d with nothing expected", got.track);
                    mismatches++;
                end
                else
                begin
                    want = pending_alerts.pop_front();
                    check_field("track_echo", want.track, got.track);
                    check_field("alert_level", want.level, got.level);
                    check_field("time_to_collision", want.ttc, got.ttc);
                    check_field("distance_echo", want.distance, got.distance);
                    check_field("speed_echo", want.speed, got.speed);
                    check_field("needed_deceleration", want.decel, got.decel);
                    checked++;
                    if (want.level == ALERT_BRAKE)
                        brakes++;
                    else if (want.level == ALERT_CAUTION)
                        cautions++;
                end
            end

            // register write; unknown indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                writes++;
                case (cfg_index)
                    CFG_TTC_BRAKE:   lim_brake     = cfg_data;
                    CFG_TTC_CAUTION: lim_caution   = cfg_data;
                    CFG_BRAKE_DIST:  brake_range   = cfg_data;
                    CFG_CAUT_DIST:   caution_range = cfg_data;
                    CFG_HYST:        hyst          = cfg_data[7:0];
                    CFG_DEF_EGO:     def_ego       = cfg_data;
                    default:         ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                predict_alert(s_axis_tdata, s_axis_tuser);
        end

        fail_count   <= mismatches;
        pending      <= pending_alerts.size();
        results_seen <= checked;
        brake_seen   <= brakes;
        caution_seen <= cautions;
        writes_seen  <= writes;
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import fcw_pkg::*;

    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int RANDOM_BATCH   = 180;
    localparam int BRAKE_RUN      = 40;
    localparam logic [5:0] RUN_TRACK = 6'd9;
    // indexes with no register behind them
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    int fail_count;
    int pending;
    int results_seen;
    int brake_seen;
    int caution_seen;
    int writes_seen;

    int idle_pct   = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    forward_collision_warning_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fcw_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .brake_seen    (brake_seen),
        .caution_seen  (caution_seen),
        .writes_seen   (writes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // alert side back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 8);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one target transaction, with an optional gap in front
    task automatic send_target(input logic [5:0] track, input logic [15:0] distance,
                               input logic [15:0] tgt, input logic [15:0] ego,
                               input logic given);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, ego, tgt, distance, track};
        s_axis_tuser  <= given;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // mostly closing targets at alert distances, some receding, some noise
    task automatic send_random_target();
        logic [5:0]  track;
        logic [15:0] distance;
        logic [15:0] tgt;
        logic [15:0] ego;
        logic        given;
        int          pick;
        pick  = $urandom_range(0, 99);
        track = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 7));
        given = ($urandom_range(0, 4) != 0);
        if (pick < 20)
        begin
            distance = 16'($urandom);
            tgt      = 16'($urandom);
            ego      = 16'($urandom);
            given    = 1'($urandom);
        end
        else if (pick < 30)
        begin
            tgt      = 16'($urandom);
            ego      = 16'($urandom_range(0, tgt));
            distance = 16'($urandom_range(0, 20000));
        end
        else
        begin
            tgt      = 16'($urandom_range(0, 30000));
            ego      = given ? 16'(tgt + $urandom_range(0, 25000)) : 16'($urandom);
            distance = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 15000));
        end
        send_target(track, distance, tgt, ego, given);
    endtask

    task automatic send_random_batch(input int count);
        repeat (count) send_random_target();
    endtask

    // lets every outstanding alert come back before the next phase
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_all(input logic [15:0] ttc_b, input logic [15:0] ttc_c,
                             input logic [15:0] dist_b, input logic [15:0] dist_c,
                             input logic [15:0] hyst, input logic [15:0] ego);
        write_reg(CFG_TTC_BRAKE, ttc_b);
        write_reg(CFG_TTC_CAUTION, ttc_c);
        write_reg(CFG_BRAKE_DIST, dist_b);
        write_reg(CFG_CAUT_DIST, dist_c);
        write_reg(CFG_HYST, hyst);
        write_reg(CFG_DEF_EGO, ego);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_TTC_BRAKE;
        cfg_data      = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 56'd0;
        s_axis_tuser  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed targets under reset settings
        idle_pct = 30;
        send_target(6'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        send_target(6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_target(6'd63, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
        // zero distance while closing
        send_target(6'd1, 16'd0, 16'd0, 16'hFFFF, 1'b1);
        // deceleration saturates at one LSB of distance
        send_target(6'd1, 16'd1, 16'd0, 16'hFFFF, 1'b1);
        // default ego speed, ego field ignored
        send_target(6'd2, 16'd2560, 16'd0, 16'd0, 1'b0);
        send_target(6'd2, 16'd1000, 16'hFFFF, 16'hFFFF, 1'b0);
        // either side of the half metre per second closing threshold
        send_target(6'd3, 16'd500, 16'd1000, 16'd1460, 1'b1);
        send_target(6'd3, 16'd500, 16'd1000, 16'd1461, 1'b1);
        // close fast target builds up to brake
        repeat (4) send_target(6'd5, 16'd1280, 16'd0, 16'd12800, 1'b1);
        // moderate closing builds up to caution
        repeat (4) send_target(6'd6, 16'd7000, 16'd5000, 16'd15360, 1'b1);
        // receding target lets track 5 decay
        repeat (3) send_target(6'd5, 16'hFFFF, 16'd20000, 16'd0, 1'b1);
        send_random_batch(RANDOM_BATCH);
        drain();

        // moderate settings, plus writes to unused indexes
        write_all(16'($urandom_range(0, 1500)), 16'($urandom_range(500, 3000)),
                  16'($urandom_range(500, 8000)), 16'($urandom_range(2000, 12000)),
                  16'($urandom_range(1, 8)), 16'($urandom_range(0, 30000)));
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0001);
        cfg_valid <= 1'b0;
        idle_pct = 0;
        send_random_batch(RANDOM_BATCH);
        drain();

        // everything at the top of its range
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF);
        cfg_valid <= 1'b0;
        idle_pct = 60;
        send_random_batch(RANDOM_BATCH);
        drain();

        // everything zero: zero hysteresis forces brake
        write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        cfg_valid <= 1'b0;
        idle_pct = 30;
        send_random_batch(RANDOM_BATCH);
        drain();

        // single-frame hysteresis with random limits
        write_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 20000)),
                  16'($urandom_range(0, 30000)), 16'd1, 16'($urandom));
        cfg_valid <= 1'b0;
        idle_pct = 45;
        send_random_batch(RANDOM_BATCH);
        drain();

        // back to reset values, no idling from here on
        write_all(16'd384, 16'd768, 16'd2560, 16'd6400, 16'd3, 16'd15360);
        cfg_valid <= 1'b0;
        idle_pct = 0;
        // hold one track at brake for a long run, then let it step down
        repeat (BRAKE_RUN) send_target(RUN_TRACK, 16'd1280, 16'd0, 16'd12800, 1'b1);
        repeat (3) send_target(RUN_TRACK, 16'hFFFF, 16'd20000, 16'd0, 1'b1);
        send_random_batch(RANDOM_BATCH);
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d alerts checked (%0d brake, %0d caution), %0d register writes",
                 results_seen, brake_seen, caution_seen, writes_seen);
        $display("tb: six register settings, brake run of %0d on track %0d",
                 BRAKE_RUN, RUN_TRACK);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
